// File: src/sds_pkg.sv
// sds_pkg: shared types and constants for the splat depth sort block.
// No dependencies; compiled first.
package sds_pkg;

    localparam int KEY_W   = 48;
    localparam int COORD_W = 32;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;
    localparam int OIDX_W  = 12;

    localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    localparam logic [CIDX_W-1:0] CFG_VIEW_X   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_VIEW_Y   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_VIEW_Z   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_VIEW_OFS = 3'd3;

    localparam logic [CFG_W-1:0] VIEW_Z_RESET = 32'h0001_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MX,
        ST_MY,
        ST_MZ,
        ST_MA,
        ST_ST,
        ST_SINIT,
        ST_SEG,
        ST_MRD,
        ST_MWR,
        ST_RD,
        ST_RO
    } state_t;

    typedef enum logic [1:0] {
        MUL_X,
        MUL_Y,
        MUL_Z
    } mul_sel_t;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      last_load;
    } in_item_t;

    typedef struct packed {
        logic [OIDX_W-1:0]       item_index;
        logic signed [KEY_W-1:0] depth_key;
        logic                    last_of_order;
        logic                    status;
        logic                    overflow;
    } out_item_t;

    typedef struct packed {
        logic     take_load;
        logic     take_read;
        logic     read_empty;
        mul_sel_t mul_sel;
        logic     acc_init;
        logic     acc_add;
        logic     store;
        logic     sort_init;
        logic     sort_done;
        logic     seg_init;
        logic     merge_wr;
        logic     read_addr;
        logic     read_out;
    } cmd_t;

    typedef struct packed {
        logic out_full;
        logic have_order;
        logic last_pending;
        logic n_le1;
        logic seg_last;
        logic pass_last;
        logic sort_last;
    } stat_t;

endpackage

// File: src/sds_in_if.sv
// sds_in_if: input channel, valid/ready with one input item as payload.
// Depends on sds_pkg.
interface sds_in_if;
    logic             valid;
    logic             ready;
    sds_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/sds_out_if.sv
// sds_out_if: result channel, valid/ready with one result item as payload.
// Depends on sds_pkg.
interface sds_out_if;
    logic              valid;
    logic              ready;
    sds_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/sds_ctrl.sv
// sds_ctrl: sequencer for key computation, merge sort passes and reads.
// Depends on sds_pkg; drives sds_dpath through cmd_t, watches stat_t.
module sds_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_command,
    output logic           in_ready,
    input  sds_pkg::stat_t stat,
    output sds_pkg::cmd_t  cmd
);

    sds_pkg::state_t state_reg;
    sds_pkg::state_t state_next;
    logic            take;

    assign in_ready = (state_reg == sds_pkg::ST_IDLE) && !stat.out_full;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sds_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (in_command == sds_pkg::CMD_LOAD)
                        state_next = sds_pkg::ST_MX;
                    else if (stat.have_order)
                        state_next = sds_pkg::ST_RD;
                end
            end
            sds_pkg::ST_MX:    state_next = sds_pkg::ST_MY;
            sds_pkg::ST_MY:    state_next = sds_pkg::ST_MZ;
            sds_pkg::ST_MZ:    state_next = sds_pkg::ST_MA;
            sds_pkg::ST_MA:    state_next = sds_pkg::ST_ST;
            sds_pkg::ST_ST:
                state_next = stat.last_pending ? sds_pkg::ST_SINIT : sds_pkg::ST_IDLE;
            sds_pkg::ST_SINIT:
                state_next = stat.n_le1 ? sds_pkg::ST_IDLE : sds_pkg::ST_SEG;
            sds_pkg::ST_SEG:   state_next = sds_pkg::ST_MRD;
            sds_pkg::ST_MRD:   state_next = sds_pkg::ST_MWR;
            sds_pkg::ST_MWR:
            begin
                if (!stat.seg_last)
                    state_next = sds_pkg::ST_MRD;
                else if (stat.pass_last && stat.sort_last)
                    state_next = sds_pkg::ST_IDLE;
                else
                    state_next = sds_pkg::ST_SEG;
            end
            sds_pkg::ST_RD:    state_next = sds_pkg::ST_RO;
            sds_pkg::ST_RO:    state_next = sds_pkg::ST_IDLE;
            default:           state_next = sds_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = sds_pkg::MUL_X;
        unique case (state_reg)
            sds_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (in_command == sds_pkg::CMD_LOAD)
                        cmd.take_load = 1'b1;
                    else if (stat.have_order)
                        cmd.take_read = 1'b1;
                    else
                        cmd.read_empty = 1'b1;
                end
            end
            sds_pkg::ST_MX:
            begin
                cmd.mul_sel  = sds_pkg::MUL_X;
                cmd.acc_init = 1'b1;
            end
            sds_pkg::ST_MY:
            begin
                cmd.mul_sel = sds_pkg::MUL_Y;
                cmd.acc_add = 1'b1;
            end
            sds_pkg::ST_MZ:
            begin
                cmd.mul_sel = sds_pkg::MUL_Z;
                cmd.acc_add = 1'b1;
            end
            sds_pkg::ST_MA:    cmd.acc_add = 1'b1;
            sds_pkg::ST_ST:    cmd.store = 1'b1;
            sds_pkg::ST_SINIT:
            begin
                cmd.sort_init = 1'b1;
                cmd.sort_done = stat.n_le1;
            end
            sds_pkg::ST_SEG:   cmd.seg_init = 1'b1;
            sds_pkg::ST_MRD:   cmd.merge_wr = 1'b0;
            sds_pkg::ST_MWR:
            begin
                cmd.merge_wr  = 1'b1;
                cmd.sort_done = stat.seg_last && stat.pass_last && stat.sort_last;
            end
            sds_pkg::ST_RD:    cmd.read_addr = 1'b1;
            sds_pkg::ST_RO:    cmd.read_out = 1'b1;
            default:           cmd.read_out = 1'b0;
        endcase
    end

endmodule

// File: src/sds_dpath.sv
// sds_dpath: config registers, key multiply-accumulate, ping-pong order
// memories with merge unit, read pointer and result register. Uses sds_pkg.
module sds_dpath
#(
    parameter int MAX_ITEMS = 4096
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  sds_pkg::cmd_t                  cmd,
    output sds_pkg::stat_t                 stat,
    input  sds_pkg::in_item_t              in_data,
    input  logic                           cfg_we,
    input  logic [sds_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [sds_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output sds_pkg::out_item_t             out_data
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int EW = sds_pkg::KEY_W + IW;
    localparam int AW = 66;

    logic signed [31:0] vx_reg, vy_reg, vz_reg, vo_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic               last_reg;
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [63:0] prod_reg;
    logic [AW-1:0]      acc_reg;
    logic [sds_pkg::KEY_W-1:0] key_sat;

    logic [CW-1:0] count_reg;
    logic [IW-1:0] pos_reg;
    logic          sorted_reg;
    logic          ovf_reg;

    logic [CW-1:0] w_reg, lo_reg, mid_reg, hi_reg, a_reg, b_reg, k_reg;
    logic          src_reg;
    logic [CW:0]   mid_sum, hi_sum, w_dbl;
    logic [CW-1:0] mid_c, hi_c;

    logic [EW-1:0] mem_a [MAX_ITEMS];
    logic [EW-1:0] mem_b [MAX_ITEMS];
    logic [EW-1:0] rda0_reg, rda1_reg, rdb0_reg, rdb1_reg;
    logic [EW-1:0] e0, e1, wd;
    logic [IW-1:0] ra0, ra1, wa;
    logic          we_a, we_b;
    logic          take_b;
    logic          a_ge_mid, b_lt_hi;
    logic signed [sds_pkg::KEY_W-1:0] ka, kb;
    logic          read_last;

    logic                out_valid_reg;
    sds_pkg::out_item_t  out_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg <= '0;
            vy_reg <= '0;
            vz_reg <= sds_pkg::VIEW_Z_RESET;
            vo_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sds_pkg::CFG_VIEW_X:   vx_reg <= cfg_data;
                sds_pkg::CFG_VIEW_Y:   vy_reg <= cfg_data;
                sds_pkg::CFG_VIEW_Z:   vz_reg <= cfg_data;
                sds_pkg::CFG_VIEW_OFS: vo_reg <= cfg_data;
                default:               vo_reg <= vo_reg;
            endcase
        end
    end

    // key: one shared multiplier, registered product, 66-bit accumulator
    always_comb
    begin
        case (cmd.mul_sel)
            sds_pkg::MUL_X: begin ma = vx_reg; mb = px_reg; end
            sds_pkg::MUL_Y: begin ma = vy_reg; mb = py_reg; end
            default:        begin ma = vz_reg; mb = pz_reg; end
        endcase
    end

    assign prod = ma * mb;

    always_comb
    begin
        if ((acc_reg[AW-1] == acc_reg[AW-2]) && (acc_reg[AW-2] == acc_reg[AW-3]))
            key_sat = acc_reg[AW-3:16];
        else if (acc_reg[AW-1])
            key_sat = sds_pkg::KEY_MIN;
        else
            key_sat = sds_pkg::KEY_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_load)
        begin
            px_reg   <= in_data.pos_x;
            py_reg   <= in_data.pos_y;
            pz_reg   <= in_data.pos_z;
            last_reg <= in_data.last_load;
        end
        prod_reg <= prod;
        if (cmd.acc_init)
            acc_reg <= {{(AW-48){vo_reg[31]}}, vo_reg, 16'h0000};
        else if (cmd.acc_add)
            acc_reg <= acc_reg + {{(AW-64){prod_reg[63]}}, prod_reg};
    end

    // merge bookkeeping
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, w_reg};
    assign mid_c    = (mid_sum >= {1'b0, count_reg}) ? count_reg : mid_sum[CW-1:0];
    assign hi_sum   = {1'b0, mid_c} + {1'b0, w_reg};
    assign hi_c     = (hi_sum >= {1'b0, count_reg}) ? count_reg : hi_sum[CW-1:0];
    assign w_dbl    = {w_reg, 1'b0};

    assign e0       = src_reg ? rdb0_reg : rda0_reg;
    assign e1       = src_reg ? rdb1_reg : rda1_reg;
    assign ka       = e0[EW-1 -: sds_pkg::KEY_W];
    assign kb       = e1[EW-1 -: sds_pkg::KEY_W];
    assign a_ge_mid = (a_reg >= mid_reg);
    assign b_lt_hi  = (b_reg < hi_reg);
    assign take_b   = b_lt_hi && (a_ge_mid || (kb < ka));

    assign stat.seg_last     = ((k_reg + CW'(1)) == hi_reg);
    assign stat.pass_last    = (hi_reg >= count_reg);
    assign stat.sort_last    = (w_dbl >= {1'b0, count_reg});
    assign stat.n_le1        = (count_reg <= CW'(1));
    assign stat.have_order   = sorted_reg && (count_reg != '0);
    assign stat.last_pending = last_reg;
    assign stat.out_full     = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pos_reg    <= '0;
            sorted_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            src_reg    <= 1'b0;
            w_reg      <= '0;
            lo_reg     <= '0;
            mid_reg    <= '0;
            hi_reg     <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            k_reg      <= '0;
        end
        else
        begin
            if (cmd.take_load && sorted_reg)
            begin
                count_reg  <= '0;
                pos_reg    <= '0;
                sorted_reg <= 1'b0;
                ovf_reg    <= 1'b0;
            end
            if (cmd.store)
            begin
                if (count_reg < CW'(MAX_ITEMS))
                    count_reg <= count_reg + CW'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.sort_init)
            begin
                w_reg   <= CW'(1);
                lo_reg  <= '0;
                src_reg <= 1'b0;
                pos_reg <= '0;
            end
            if (cmd.seg_init)
            begin
                mid_reg <= mid_c;
                hi_reg  <= hi_c;
                a_reg   <= lo_reg;
                b_reg   <= mid_c;
                k_reg   <= lo_reg;
            end
            if (cmd.merge_wr)
            begin
                k_reg <= k_reg + CW'(1);
                if (take_b)
                    b_reg <= b_reg + CW'(1);
                else
                    a_reg <= a_reg + CW'(1);
                if (stat.seg_last)
                begin
                    if (stat.pass_last)
                    begin
                        lo_reg  <= '0;
                        w_reg   <= w_dbl[CW-1:0];
                        src_reg <= !src_reg;
                    end
                    else
                    begin
                        lo_reg <= hi_reg;
                    end
                end
            end
            if (cmd.sort_done)
                sorted_reg <= 1'b1;
            if (cmd.read_out)
                pos_reg <= read_last ? '0 : pos_reg + IW'(1);
        end
    end

    // order memories: {key, load index}; loads fill A, passes ping-pong
    assign ra0  = cmd.read_addr ? pos_reg : a_reg[IW-1:0];
    assign ra1  = b_reg[IW-1:0];
    assign wa   = cmd.store ? count_reg[IW-1:0] : k_reg[IW-1:0];
    assign wd   = cmd.store ? {key_sat, count_reg[IW-1:0]} : (take_b ? e1 : e0);
    assign we_a = (cmd.store && (count_reg < CW'(MAX_ITEMS))) || (cmd.merge_wr && src_reg);
    assign we_b = cmd.merge_wr && !src_reg;

    always_ff @(posedge clk)
    begin
        if (we_a)
            mem_a[wa] <= wd;
        rda0_reg <= mem_a[ra0];
        rda1_reg <= mem_a[ra1];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            mem_b[wa] <= wd;
        rdb0_reg <= mem_b[ra0];
        rdb1_reg <= mem_b[ra1];
    end

    // result register
    assign read_last = ((CW'(pos_reg) + CW'(1)) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.read_empty || cmd.read_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_empty)
        begin
            out_reg.item_index    <= '0;
            out_reg.depth_key     <= '0;
            out_reg.last_of_order <= 1'b0;
            out_reg.status        <= 1'b1;
            out_reg.overflow      <= ovf_reg;
        end
        else if (cmd.read_out)
        begin
            out_reg.item_index    <= sds_pkg::OIDX_W'(e0[IW-1:0]);
            out_reg.depth_key     <= ka;
            out_reg.last_of_order <= read_last;
            out_reg.status        <= 1'b0;
            out_reg.overflow      <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("item count above capacity");
    a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_wr |-> (k_reg < hi_reg) && (a_reg <= mid_reg) && (b_reg <= hi_reg))
        else $error("merge pointers out of segment");
    a_merge_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_wr |-> (a_reg < mid_reg) || b_lt_hi)
        else $error("merge step with both runs empty");
    a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_out |-> stat.have_order && (CW'(pos_reg) < count_reg))
        else $error("read without a sorted order");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_reg))
        else $error("pending result item lost");
`endif

endmodule

// File: src/splat_depth_sort.sv
// splat_depth_sort: top level; joins sds_ctrl and sds_dpath to the channels.
// Depends on sds_pkg, sds_in_if, sds_out_if, sds_ctrl, sds_dpath.
//
// For a load item the depth key is formed by one shared 32x32
// multiplier over the three coordinates into a 66-bit accumulator, then
// saturated and written to the order memory. The load marked last starts a
// bottom-up stable merge sort over two ping-pong memories holding
// {key, index}; each merged entry takes a registered read, then a compare
// and write, and each segment begins with a setup step; no item is accepted
// during the sort. A read item passes through the registered memory read;
// a read with no order available goes straight to the result register.
// One item is in work at a time; a finished result that has not been taken
// holds off the next item.
module splat_depth_sort
#(
    parameter int MAX_ITEMS = 4096
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    sds_in_if.sink                      in_ch,
    sds_out_if.source                   out_ch,
    input  logic                        cfg_we,
    input  logic [sds_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [sds_pkg::CFG_W-1:0]   cfg_data
);

    sds_pkg::cmd_t  cmd;
    sds_pkg::stat_t stat;

    sds_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.data.command),
        .in_ready   (in_ch.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    sds_dpath #(.MAX_ITEMS(MAX_ITEMS)) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_ch.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_data  (out_ch.data)
    );

endmodule

// File: test/splat_depth_sort_tb.sv
// splat_depth_sort_tb: self-checking bench for the splat depth sort block.
// Depends on sds_pkg, sds_in_if, sds_out_if and splat_depth_sort.
// A predictor forms keys and the stable back-to-front order; a checker compares each result.
`timescale 1ns / 100ps

module splat_depth_sort_tb;

    localparam int CAPACITY = 4096;
    localparam int LIMIT    = 4000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sds_pkg::CIDX_W-1:0] cfg_index;
    logic [sds_pkg::CFG_W-1:0]  cfg_data;

    sds_in_if  in_ch ();
    sds_out_if out_ch ();

    splat_depth_sort #(.MAX_ITEMS(CAPACITY)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic signed [sds_pkg::CFG_W-1:0] view_reg [4];
    logic signed [sds_pkg::KEY_W-1:0] key_mem [CAPACITY];
    logic [sds_pkg::OIDX_W-1:0]       sorted_idx [CAPACITY];
    int unsigned             set_count;
    int unsigned             read_pos;
    bit                      order_valid;
    bit                      dropped_seen;

    sds_pkg::out_item_t expected_results [$];

    int  errors;
    int  cycles;
    int  loads_sent;
    int  reads_sent;
    int  results_seen;
    int  overflow_sets;
    bit  quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic signed [sds_pkg::KEY_W-1:0] view_depth(logic signed [31:0] x,
                                                                    logic signed [31:0] y,
                                                                    logic signed [31:0] z);
        logic signed [79:0] acc;
        logic signed [79:0] term;
        longint kmax;
        longint kmin;
        kmax = 64'sh0000_7FFF_FFFF_FFFF;
        kmin = -kmax - 1;
        term = 80'(longint'(view_reg[0]) * longint'(x));
        acc  = term;
        term = 80'(longint'(view_reg[1]) * longint'(y));
        acc  = acc + term;
        term = 80'(longint'(view_reg[2]) * longint'(z));
        acc  = acc + term;
        term = 80'(view_reg[3]);
        acc  = acc + (term <<< 16);
        acc  = acc >>> 16;
        if (acc > 80'(kmax))
            acc = 80'(kmax);
        if (acc < 80'(kmin))
            acc = 80'(kmin);
        return acc[sds_pkg::KEY_W-1:0];
    endfunction

    function automatic void build_order();
        bit [sds_pkg::KEY_W+sds_pkg::OIDX_W-1:0] tags [];
        tags = new[set_count];
        for (int i = 0; i < set_count; i++)
            tags[i] = {~key_mem[i][sds_pkg::KEY_W-1], key_mem[i][sds_pkg::KEY_W-2:0],
                       sds_pkg::OIDX_W'(i)};
        tags.sort();
        for (int i = 0; i < set_count; i++)
            sorted_idx[i] = tags[i][sds_pkg::OIDX_W-1:0];
    endfunction

    function automatic void predict_item(sds_pkg::in_item_t it);
        sds_pkg::out_item_t r;
        if (it.command == sds_pkg::CMD_LOAD)
        begin
            loads_sent++;
            if (order_valid)
            begin
                set_count    = 0;
                read_pos     = 0;
                order_valid  = 1'b0;
                dropped_seen = 1'b0;
            end
            if (set_count < CAPACITY)
            begin
                key_mem[set_count] = view_depth(it.pos_x, it.pos_y, it.pos_z);
                set_count++;
            end
            else
                dropped_seen = 1'b1;
            if (it.last_load)
            begin
                if (dropped_seen)
                    overflow_sets++;
                build_order();
                order_valid = 1'b1;
                read_pos    = 0;
            end
            return;
        end
        reads_sent++;
        r = '0;
        r.overflow = dropped_seen;
        if (!order_valid || set_count == 0)
            r.status = 1'b1;
        else
        begin
            if (read_pos >= set_count)
                read_pos = 0;
            r.item_index    = sorted_idx[read_pos];
            r.depth_key     = key_mem[sorted_idx[read_pos]];
            r.last_of_order = (read_pos + 1 == set_count);
            read_pos        = r.last_of_order ? 0 : read_pos + 1;
        end
        expected_results.insert(expected_results.size(), r);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        sds_pkg::out_item_t e;
        sds_pkg::out_item_t a;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            a = out_ch.data;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: index %0d", a.item_index);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (a.item_index !== e.item_index)
                begin
                    $error("item_index: expected %0d, got %0d", e.item_index, a.item_index);
                    errors++;
                end
                if (a.depth_key !== e.depth_key)
                begin
                    $error("depth_key: expected %0d, got %0d", e.depth_key, a.depth_key);
                    errors++;
                end
                if (a.last_of_order !== e.last_of_order)
                begin
                    $error("last_of_order: expected %0d, got %0d", e.last_of_order,
                           a.last_of_order);
                    errors++;
                end
                if (a.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, a.status);
                    errors++;
                end
                if (a.overflow !== e.overflow)
                begin
                    $error("overflow: expected %0d, got %0d", e.overflow, a.overflow);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (quiet || $urandom_range(0, 3) != 0)
            begin
                n = $urandom_range(1, 20);
                out_ch.ready <= 1'b1;
            end
            else
            begin
                n = $urandom_range(1, 9);
                out_ch.ready <= 1'b0;
            end
            repeat (n) @(posedge clk);
        end
    end

    task automatic send_item(logic cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic last);
        sds_pkg::in_item_t it;
        int gap;
        it.command   = cmd;
        it.pos_x     = x;
        it.pos_y     = y;
        it.pos_z     = z;
        it.last_load = last;
        gap = (quiet || $urandom_range(0, 4) != 0) ? 0 : $urandom_range(1, 9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_item(it);
    endtask

    task automatic load(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        send_item(sds_pkg::CMD_LOAD, x, y, z, last);
    endtask

    task automatic read_next();
        send_item(sds_pkg::CMD_READ, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // a read behind any pending sort proves the block idle
    task automatic settle();
        drain();
        @(posedge clk);
        read_next();
        drain();
        repeat (10) @(posedge clk);
    endtask

    task automatic write_view(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                              logic [31:0] vo);
        logic [31:0] vals [4];
        vals = '{vx, vy, vz, vo};
        settle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= sds_pkg::CIDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            view_reg[i] = vals[i];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_no_order();
        read_next();
        read_next();
    endtask

    task automatic test_reset_view();
        load(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        load(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
        load(0, 0, 32'hFFFF_FFFF, 1'b0);
        read_next();
        load(5, 6, 32'hFFFF_FFFF, 1'b0);
        load(0, 0, 32'h0001_0000, 1'b1);
        repeat (7) read_next();
    endtask

    task automatic test_saturation();
        write_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        load(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        load(0, 0, 0, 1'b1);
        repeat (5) read_next();
        write_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        load(1, 1, 1, 1'b1);
        repeat (3) read_next();
    endtask

    task automatic test_single();
        write_view(0, 0, 0, 32'hFFFF_FFFF);
        load(1, 2, 3, 1'b1);
        repeat (3) read_next();
    endtask

    task automatic test_random(int items);
        int sent;
        int n;
        int reads;
        sent = 0;
        while (sent < items)
        begin
            if (sent > items * 85 / 100)
                quiet = 1'b1;
            if (!quiet)
            begin
                case ($urandom_range(0, 7))
                    0: write_view($urandom, $urandom, $urandom, $urandom);
                    1: write_view(32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh20000),
                                  32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh20000),
                                  32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh20000),
                                  $urandom);
                    2: settle();
                    default: ;
                endcase
            end
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    read_next();
                    sent++;
                end
                load(pick_coord(), pick_coord(), pick_coord(), i == n - 1);
                sent++;
            end
            reads = (n > 40) ? $urandom_range(0, 8) : n + $urandom_range(0, n / 2 + 2);
            repeat (reads)
            begin
                read_next();
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        errors       = 0;
        cycles       = 0;
        loads_sent   = 0;
        reads_sent   = 0;
        results_seen = 0;
        overflow_sets = 0;
        quiet        = 1'b0;
        view_reg     = '{32'sd0, 32'sd0, sds_pkg::VIEW_Z_RESET, 32'sd0};
        set_count    = 0;
        read_pos     = 0;
        order_valid  = 1'b0;
        dropped_seen = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_order();
        test_reset_view();
        test_saturation();
        test_single();
        test_random(1600);

        drain();
        repeat (50) @(posedge clk);
        $display("Covered %0d loads, %0d reads, %0d results, %0d overflowing sets,",
                 loads_sent, reads_sent, results_seen, overflow_sets);
        $display("with saturated keys, tied keys, wraparound and reads without an order.");
        if (errors == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
src/sds_pkg.sv
src/sds_in_if.sv
src/sds_out_if.sv
src/sds_ctrl.sv
src/sds_dpath.sv
src/splat_depth_sort.sv
test/splat_depth_sort_tb.sv
